// ----- src/vhp_pkg.sv -----
package vhp_pkg;

	// Field widths of the byte stream and the verdict
	localparam int BYTE_W    = 8;
	localparam int RATE_W    = 8;
	localparam int MAX_W     = 24;
	localparam int SIZE_W    = 32;
	localparam int FCOUNT_W  = 21;
	localparam int OFFSET_W  = 24;
	localparam int TDATA_W   = 128;
	localparam int TUSER_W   = 4;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA     = 1'd1;
	localparam logic [RATE_W-1:0]    DEFAULT_RATE_RST = 8'd50;
	localparam logic [MAX_W-1:0]     MAX_DATA_RST     = 24'd1048576;

	// Magic characters
	localparam logic [BYTE_W-1:0] CH_A = 8'h61;
	localparam logic [BYTE_W-1:0] CH_Y = 8'h79;
	localparam logic [BYTE_W-1:0] CH_M = 8'h6d;

	// Number of zero-terminated strings after the header
	localparam int NUM_STRINGS = 5;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_TRUNC = 3'd1,
		ERR_MAGIC = 3'd2,
		ERR_SIZE  = 3'd3,
		ERR_LARGE = 3'd4,
		ERR_POS   = 3'd5
	} err_t;

	// Verdict passed from the parser through the queue to the output stage
	typedef struct packed {
		logic                ok;
		err_t                error_code;
		logic                ym_chip;
		logic [7:0]          stereo_mode;
		logic [15:0]         loop_start;
		logic [31:0]         psg_clock;
		logic [RATE_W-1:0]   rate_raw;
		logic [15:0]         year;
		logic [MAX_W-1:0]    data_size;
		logic [OFFSET_W-1:0] payload_offset;
	} verdict_t;

	// Output word layout, lowest field in the lowest bits
	typedef struct packed {
		logic [1:0]          pad;
		logic [OFFSET_W-1:0] payload_offset;
		logic [FCOUNT_W-1:0] num_frames;
		logic [15:0]         year;
		logic [RATE_W-1:0]   play_rate;
		logic [31:0]         psg_clock;
		logic [15:0]         loop_start;
		logic [7:0]          stereo_mode;
		logic                ym_chip;
	} out_data_t;

	// Status word layout
	typedef struct packed {
		err_t error_code;
		logic ok;
	} out_user_t;

endpackage

// ----- src/vhp_front.sv -----
module vhp_front #(
	parameter int POS_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_take,
	input  logic [vhp_pkg::BYTE_W-1:0] byte_value,
	input  logic                       last_byte,
	input  logic [vhp_pkg::MAX_W-1:0]  max_data_bytes,
	output logic                       push,
	output vhp_pkg::verdict_t          verdict
);
	import vhp_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_STRINGS,
		PH_WAIT,
		PH_DATA,
		PH_FAIL
	} phase_t;

	localparam logic [POS_BITS-1:0] POS_LIMIT = '1;
	localparam logic [2:0] STR_LAST = 3'(NUM_STRINGS - 1);

	// Reduce a value below 374 modulo 14 by reciprocal multiply
	function automatic logic [3:0] mod14(input logic [8:0] v);
		logic [17:0] prod;
		logic [4:0]  quo;
		logic [8:0]  back;
		prod = 18'(v) * 18'd293;
		quo  = prod[16:12];
		back = 9'(quo) * 9'd14;
		return 4'(v - back);
	endfunction

	phase_t            phase_q, phase_n;
	logic [POS_BITS-1:0] pos_q, pos_n;
	logic [2:0]        strings_q, strings_n;
	err_t              err_q, err_n;

	logic              ym_q, ym_n;
	logic [7:0]        stereo_q, stereo_n;
	logic [15:0]       loop_q, loop_n;
	logic [31:0]       clock_q, clock_n;
	logic [7:0]        rate_q, rate_n;
	logic [15:0]       year_q, year_n;
	logic [SIZE_W-1:0] size_q, size_n;
	logic [3:0]        res_q, res_n;

	logic [3:0]        hdr_idx;
	logic [1:0]        clk_sel;
	logic [5:0]        nib_sum;
	logic [8:0]        res_term;
	logic [8:0]        res_sum;
	logic [3:0]        res_step;
	logic [SIZE_W-1:0] size_full;

	assign hdr_idx   = pos_q[3:0];
	assign clk_sel   = 2'(hdr_idx - 4'd5);
	assign size_full = {byte_value, size_q[23:0]};

	// Running residue of the size: byte weights 1, 4, 2, 8 modulo 14
	always_comb begin
		nib_sum = 6'(byte_value[7:4]) * 6'd2 + 6'(byte_value[3:0]);
		case (hdr_idx[1:0])
			2'd0:    res_term = 9'(nib_sum);
			2'd1:    res_term = 9'(nib_sum) << 2;
			2'd2:    res_term = 9'(nib_sum) << 1;
			default: res_term = 9'(nib_sum) << 3;
		endcase
		res_sum  = res_term + ((hdr_idx[1:0] == 2'd0) ? 9'd0 : 9'(res_q));
		res_step = mod14(res_sum);
	end

	// Next parser state for the incoming byte
	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		strings_n = strings_q;
		err_n     = err_q;
		ym_n      = ym_q;
		stereo_n  = stereo_q;
		loop_n    = loop_q;
		clock_n   = clock_q;
		rate_n    = rate_q;
		year_n    = year_q;
		size_n    = size_q;
		res_n     = res_q;
		unique case (phase_q)
			PH_HEADER: begin
				pos_n = pos_q + 1'b1;
				unique case (hdr_idx) inside
					4'd0: begin
						if (byte_value == CH_A) begin
							ym_n = 1'b0;
						end else if (byte_value == CH_Y) begin
							ym_n = 1'b1;
						end else begin
							err_n   = ERR_MAGIC;
							phase_n = PH_FAIL;
						end
					end
					4'd1: begin
						if (byte_value != (ym_q ? CH_M : CH_Y)) begin
							err_n   = ERR_MAGIC;
							phase_n = PH_FAIL;
						end
					end
					4'd2: stereo_n = byte_value;
					[4'd3:4'd4]: loop_n[{hdr_idx == 4'd4, 3'b000} +: 8] = byte_value;
					[4'd5:4'd8]: clock_n[{clk_sel, 3'b000} +: 8] = byte_value;
					4'd9: rate_n = byte_value;
					[4'd10:4'd11]: year_n[{hdr_idx[0], 3'b000} +: 8] = byte_value;
					[4'd12:4'd15]: begin
						size_n[{hdr_idx[1:0], 3'b000} +: 8] = byte_value;
						res_n = res_step;
						// Last size byte: check in stream order
						if (hdr_idx == 4'd15) begin
							if (size_full == '0 || res_step != 4'd0) begin
								err_n   = ERR_SIZE;
								phase_n = PH_FAIL;
							end else if (size_full > SIZE_W'(max_data_bytes)) begin
								err_n   = ERR_LARGE;
								phase_n = PH_FAIL;
							end else begin
								phase_n = PH_STRINGS;
							end
						end
					end
					default: ;
				endcase
			end
			PH_STRINGS: begin
				if (pos_q == POS_LIMIT) begin
					if (!last_byte) begin
						err_n   = ERR_POS;
						phase_n = PH_FAIL;
					end
				end else begin
					pos_n = pos_q + 1'b1;
					if (byte_value == '0) begin
						strings_n = strings_q + 3'd1;
						if (strings_q == STR_LAST) begin
							phase_n = PH_WAIT;
						end
					end
				end
			end
			PH_WAIT: phase_n = PH_DATA;
			PH_DATA, PH_FAIL: ;
			default: ;
		endcase
	end

	// Build the verdict from the state after this byte
	always_comb begin
		verdict = '0;
		if (phase_n == PH_FAIL) begin
			verdict.error_code = err_n;
		end else if (phase_n != PH_DATA) begin
			verdict.error_code = ERR_TRUNC;
		end else begin
			verdict.ok             = 1'b1;
			verdict.error_code     = ERR_NONE;
			verdict.ym_chip        = ym_n;
			verdict.stereo_mode    = stereo_n;
			verdict.loop_start     = loop_n;
			verdict.psg_clock      = clock_n;
			verdict.rate_raw       = rate_n;
			verdict.year           = year_n;
			verdict.data_size      = size_n[MAX_W-1:0];
			verdict.payload_offset = OFFSET_W'(pos_n);
		end
	end

	assign push = in_take && last_byte;

	// Hold control state, rearm after the last byte of a file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			strings_q <= '0;
			err_q     <= ERR_NONE;
		end else if (in_take) begin
			if (last_byte) begin
				phase_q   <= PH_HEADER;
				pos_q     <= '0;
				strings_q <= '0;
				err_q     <= ERR_NONE;
			end else begin
				phase_q   <= phase_n;
				pos_q     <= pos_n;
				strings_q <= strings_n;
				err_q     <= err_n;
			end
		end
	end

	// Header fields, each overwritten before it is reported
	always_ff @(posedge clk) begin
		if (in_take) begin
			ym_q     <= ym_n;
			stereo_q <= stereo_n;
			loop_q   <= loop_n;
			clock_q  <= clock_n;
			rate_q   <= rate_n;
			year_q   <= year_n;
			size_q   <= size_n;
			res_q    <= res_n;
		end
	end

endmodule

// ----- src/vhp_queue.sv -----
module vhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vhp_pkg::verdict_t push_data,
	output logic              full,
	output logic              head_valid,
	output vhp_pkg::verdict_t head_data,
	input  logic              pop
);
	import vhp_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	verdict_t          entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the verdict word
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- src/vhp_back.sv -----
module vhp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  vhp_pkg::verdict_t           in_data,
	output logic                        pop,
	input  logic [vhp_pkg::RATE_W-1:0]  default_rate_hz,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output vhp_pkg::out_data_t          out_data,
	output vhp_pkg::out_user_t          out_user
);
	import vhp_pkg::*;

	// Quotient by 14 as multiply by ceil(2^28 / 14), exact below 2^24
	localparam int          RECIP_SHIFT = 28;
	localparam int          PROD_W      = MAX_W + 25;
	localparam logic [24:0] RECIP_14    = 25'd19173962;

	logic              m_tvalid_q;
	out_data_t         data_q;
	out_user_t         user_q;
	logic [PROD_W-1:0] prod;
	logic [RATE_W-1:0] rate;

	assign pop = in_valid && (!m_tvalid_q || m_tready);

	always_comb begin
		prod = PROD_W'(in_data.data_size) * PROD_W'(RECIP_14);
		if (in_data.ok && in_data.rate_raw == '0) begin
			rate = default_rate_hz;
		end else begin
			rate = in_data.rate_raw;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Load the finished verdict
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q.pad            <= '0;
			data_q.payload_offset <= in_data.payload_offset;
			data_q.num_frames     <= prod[RECIP_SHIFT +: FCOUNT_W];
			data_q.year           <= in_data.year;
			data_q.play_rate      <= rate;
			data_q.psg_clock      <= in_data.psg_clock;
			data_q.loop_start     <= in_data.loop_start;
			data_q.stereo_mode    <= in_data.stereo_mode;
			data_q.ym_chip        <= in_data.ym_chip;
			user_q.ok             <= in_data.ok;
			user_q.error_code     <= in_data.error_code;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign out_data = data_q;
	assign out_user = user_q;

endmodule

// ----- src/vtx_header_parser_core.sv -----
// VTX file header parser.
// Slave stream: one file byte per word in s_tdata, s_tlast on the final byte
// of a file. Master stream: one verdict word per file, status in m_tuser and
// header fields in m_tdata.
// Configuration: cfg_we with cfg_index 0 sets the default frame rate (used
// when the header rate byte is zero), index 1 the largest accepted register
// data size. Write only while no file is in flight.
// Throughput: one byte per cycle while the queue is not full. The parser
// updates its state with each byte taken and, on the last byte, pushes a
// verdict into a four-entry queue; an output stage drains the queue one
// verdict per cycle while m_tready is high, computing size / 14 with one
// reciprocal multiply. With the queue empty and the output register free,
// the verdict goes into the queue and then into the output register.
// Stall: with m_tready low, the output word holds and the queue fills;
// s_tready drops only when the queue is full.
// Reset: the parser rearms at the start of a file, the queue empties and the
// configuration registers return to rate 50 and size limit 1048576.
module vtx_header_parser_core #(
	parameter int POS_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // byte_value
	input  logic                          s_tlast,   // last_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// ym_chip, stereo_mode, loop_start, psg_clock, play_rate,
	// year, num_frames, payload_offset, zero pad
	output logic [vhp_pkg::TDATA_W-1:0]   m_tdata,
	output logic [vhp_pkg::TUSER_W-1:0]   m_tuser,   // ok, error_code
	input  logic                          cfg_we,
	input  logic [vhp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vhp_pkg::MAX_W-1:0]     cfg_wdata
);
	import vhp_pkg::*;

	logic [RATE_W-1:0] default_rate_q;
	logic [MAX_W-1:0]  max_data_q;
	logic              in_take;
	logic              push;
	logic              full;
	logic              head_valid;
	logic              pop;
	verdict_t          push_data;
	verdict_t          head_data;
	out_data_t         out_data;
	out_user_t         out_user;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_rate_q <= DEFAULT_RATE_RST;
			max_data_q     <= MAX_DATA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEFAULT_RATE: default_rate_q <= cfg_wdata[RATE_W-1:0];
				CFG_MAX_DATA:     max_data_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_tready = !full;
	assign in_take  = s_tvalid && s_tready;

	vhp_front #(
		.POS_BITS (POS_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_take        (in_take),
		.byte_value     (s_tdata),
		.last_byte      (s_tlast),
		.max_data_bytes (max_data_q),
		.push           (push),
		.verdict        (push_data)
	);

	vhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	vhp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (head_valid),
		.in_data         (head_data),
		.pop             (pop),
		.default_rate_hz (default_rate_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.out_data        (out_data),
		.out_user        (out_user)
	);

	assign m_tdata = out_data;
	assign m_tuser = out_user;

endmodule

// ----- src/vhp_checker.sv -----
module vhp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [vhp_pkg::TDATA_W-1:0] m_tdata,
	input logic [vhp_pkg::TUSER_W-1:0] m_tuser
);
	import vhp_pkg::*;

	out_data_t d;
	out_user_t u;

	assign d = m_tdata;
	assign u = m_tuser;

	// Stalled verdict holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("verdict dropped or changed under stall");

	// Accepted file carries no error code, rejected one always does
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (u.ok == (u.error_code == ERR_NONE)))
		else $error("ok flag and error code disagree");

	// Rejected file reports no header fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !u.ok |-> m_tdata == '0)
		else $error("fields not cleared on failure");

	// Accepted file reports a nonzero frame count
	a_frames: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && u.ok |-> d.num_frames != '0)
		else $error("zero frame count on accepted file");

endmodule

bind vtx_header_parser_core vhp_checker u_vhp_checker (.*);

// ----- tb/sv/vtx_header_parser_core_tb.sv -----
module vtx_header_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vhp_pkg::*;

	// Position counter width handed to the block
	localparam int          POS_BITS    = 16;
	localparam logic [31:0] POS_LIMIT   = (32'd1 << POS_BITS) - 32'd1;
	localparam int          FRAME_BYTES = 14;
	localparam int          STRING_CNT  = 5;
	localparam int          CYCLE_LIMIT = 1500000;
	localparam int          SETTLE      = 8;

	typedef logic [7:0] octet_t;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_STRINGS,
		ST_WAIT,
		ST_DATA,
		ST_FAIL
	} parse_state_e;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;
	logic [TUSER_W-1:0]   m_tuser;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MAX_W-1:0]     cfg_wdata;

	// Header parse predictor and the queue of verdicts it expects
	class verdict_board;
		logic [7:0]   dflt_rate;
		logic [23:0]  size_cap;
		logic [31:0]  pos;
		parse_state_e state;
		int unsigned  strings_seen;
		logic         ym;
		logic [7:0]   stereo;
		logic [15:0]  loop_fr;
		logic [31:0]  clock_hz;
		logic [7:0]   rate;
		logic [15:0]  yr;
		logic [31:0]  size;
		err_t         err;
		out_data_t    want_data[$];
		out_user_t    want_user[$];
		int unsigned  mismatches;
		int unsigned  files;
		int unsigned  ok_count;
		int unsigned  code_count[8];

		function new();
			dflt_rate = DEFAULT_RATE_RST;
			size_cap = MAX_DATA_RST;
			mismatches = 0;
			files = 0;
			ok_count = 0;
			foreach (code_count[i]) code_count[i] = 0;
			rearm();
		endfunction

		function void rearm();
			pos = '0;
			state = ST_HEADER;
			strings_seen = 0;
			ym = 1'b0;
			stereo = '0;
			loop_fr = '0;
			clock_hz = '0;
			rate = '0;
			yr = '0;
			size = '0;
			err = ERR_NONE;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MAX_W-1:0] value);
			if (idx == CFG_DEFAULT_RATE) dflt_rate = value[7:0];
			else size_cap = value;
		endfunction

		function void abort(err_t code);
			err = code;
			state = ST_FAIL;
		endfunction

		function void header_byte(octet_t b);
			if (pos == 0) begin
				if (b == CH_A) ym = 1'b0;
				else if (b == CH_Y) ym = 1'b1;
				else begin
					abort(ERR_MAGIC);
					return;
				end
			end else if (pos == 1) begin
				if (b != (ym ? CH_M : CH_Y)) begin
					abort(ERR_MAGIC);
					return;
				end
			end else if (pos == 2) begin
				stereo = b;
			end else if (pos <= 4) begin
				loop_fr[8*(pos-3) +: 8] = b;
			end else if (pos <= 8) begin
				clock_hz[8*(pos-5) +: 8] = b;
			end else if (pos == 9) begin
				rate = b;
			end else if (pos <= 11) begin
				yr[8*(pos-10) +: 8] = b;
			end else begin
				size[8*(pos-12) +: 8] = b;
				// size checks come before any end-of-file check
				if (pos == 15) begin
					if (size == 0 || size % FRAME_BYTES != 0) begin
						abort(ERR_SIZE);
						return;
					end
					if (size > {8'd0, size_cap}) begin
						abort(ERR_LARGE);
						return;
					end
					state = ST_STRINGS;
				end
			end
			pos++;
		endfunction

		function void string_byte(octet_t b, logic last);
			// a non-final byte at the top position cannot reach the payload
			if (pos >= POS_LIMIT) begin
				if (!last) abort(ERR_POS);
				return;
			end
			if (b == 8'd0) begin
				strings_seen++;
				if (strings_seen >= STRING_CNT) state = ST_WAIT;
			end
			pos++;
		endfunction

		// Advance the parse by one accepted word; queue a verdict on the last byte
		function void take_byte(octet_t b, logic last);
			out_data_t d;
			out_user_t u;
			case (state)
				ST_HEADER:  header_byte(b);
				ST_STRINGS: string_byte(b, last);
				ST_WAIT:    state = ST_DATA;
				default:    ;
			endcase
			if (!last) return;
			d = '0;
			u = '0;
			if (state == ST_FAIL) begin
				u.error_code = err;
			end else if (state != ST_DATA) begin
				u.error_code = ERR_TRUNC;
			end else begin
				u.ok = 1'b1;
				u.error_code = ERR_NONE;
				d.ym_chip = ym;
				d.stereo_mode = stereo;
				d.loop_start = loop_fr;
				d.psg_clock = clock_hz;
				d.play_rate = (rate != 0) ? rate : dflt_rate;
				d.year = yr;
				d.num_frames = FCOUNT_W'(size / FRAME_BYTES);
				d.payload_offset = pos[OFFSET_W-1:0];
				ok_count++;
			end
			code_count[u.error_code]++;
			files++;
			want_data.push_back(d);
			want_user.push_back(u);
			rearm();
		endfunction

		function int unsigned pending();
			return want_data.size();
		endfunction

		function void field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one verdict word against the oldest expectation
		function void check_word(logic [TDATA_W-1:0] data, logic [TUSER_W-1:0] user);
			out_data_t d;
			out_user_t u;
			out_data_t e;
			out_user_t eu;
			d = out_data_t'(data);
			u = out_user_t'(user);
			if (want_data.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, actual tuser %0h tdata %0h",
					$time, user, data);
				mismatches++;
				return;
			end
			e = want_data.pop_front();
			eu = want_user.pop_front();
			field("ok", 64'(eu.ok), 64'(u.ok));
			field("error_code", 64'(eu.error_code), 64'(u.error_code));
			field("ym_chip", 64'(e.ym_chip), 64'(d.ym_chip));
			field("stereo_mode", 64'(e.stereo_mode), 64'(d.stereo_mode));
			field("loop_start", 64'(e.loop_start), 64'(d.loop_start));
			field("psg_clock", 64'(e.psg_clock), 64'(d.psg_clock));
			field("play_rate", 64'(e.play_rate), 64'(d.play_rate));
			field("year", 64'(e.year), 64'(d.year));
			field("num_frames", 64'(e.num_frames), 64'(d.num_frames));
			field("payload_offset", 64'(e.payload_offset), 64'(d.payload_offset));
		endfunction
	endclass

	verdict_board board = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_left;
	int unsigned cycle_count;
	int unsigned bytes_total;
	int unsigned rand_bytes;
	int unsigned rand_files;
	int unsigned cfg_writes;

	vtx_header_parser_core #(
		.POS_BITS(POS_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bail out if the run hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
			board.pending());
		$display("TB_ERROR");
		$finish;
	end

	// Verdict side: check accepted words, stall at random or for a hold-off
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) board.check_word(m_tdata, m_tuser);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offer one byte, idling first at random, and hold it until taken
	task automatic push_byte(octet_t b, logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.take_byte(b, last);
		bytes_total++;
	endtask

	task automatic send_file(ref octet_t f[$]);
		int i;
		for (i = 0; i < f.size(); i++) push_byte(f[i], i == f.size() - 1);
	endtask

	// Drop valid, wait out every verdict, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAX_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, value);
		cfg_writes++;
		@(posedge clk);
	endtask

	function automatic void add_header(ref octet_t f[$], input octet_t m0, octet_t m1,
		logic [7:0] stereo, logic [15:0] loop_fr, logic [31:0] clk_hz, logic [7:0] rate,
		logic [15:0] yr, logic [31:0] size);
		int i;
		f.push_back(m0);
		f.push_back(m1);
		f.push_back(stereo);
		for (i = 0; i < 2; i++) f.push_back(loop_fr[8*i +: 8]);
		for (i = 0; i < 4; i++) f.push_back(clk_hz[8*i +: 8]);
		f.push_back(rate);
		for (i = 0; i < 2; i++) f.push_back(yr[8*i +: 8]);
		for (i = 0; i < 4; i++) f.push_back(size[8*i +: 8]);
	endfunction

	// Append the five strings, each up to max_len nonzero bytes plus its terminator
	function automatic void add_strings(ref octet_t f[$], input int unsigned max_len);
		int s;
		for (s = 0; s < STRING_CNT; s++) begin
			repeat ($urandom_range(0, max_len)) f.push_back(8'($urandom_range(1, 255)));
			f.push_back(8'd0);
		end
	endfunction

	// Mostly well-formed files with random content, some cut, corrupted or noise
	function automatic void rand_file(ref octet_t f[$]);
		int unsigned pick;
		int unsigned frames_top;
		int unsigned cut;
		logic [31:0] size;
		logic        ym;
		f.delete();
		pick = $urandom_range(0, 99);
		ym = 1'($urandom_range(0, 1));
		frames_top = board.size_cap / FRAME_BYTES;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: size = FRAME_BYTES * $urandom_range(1, 40);
			5: size = FRAME_BYTES * frames_top;
			6: size = FRAME_BYTES * $urandom_range(1, frames_top);
			7: size = FRAME_BYTES * (frames_top + $urandom_range(1, 3));
			8: size = $urandom;
			default: size = FRAME_BYTES * $urandom_range(1, 40) + $urandom_range(1, 13);
		endcase
		if (pick < 3) size = '0;
		add_header(f, ym ? CH_Y : CH_A, ym ? CH_M : CH_Y, 8'($urandom), 16'($urandom),
			$urandom, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom), 16'($urandom), size);
		add_strings(f, 3);
		repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
		if (pick >= 70 && pick < 85) begin
			cut = $urandom_range(1, f.size() - 1);
			f = f[0:cut-1];
		end else if (pick >= 85 && pick < 92) begin
			f[$urandom_range(0, 1)] = 8'($urandom);
		end else if (pick >= 92) begin
			f.delete();
			repeat ($urandom_range(1, 24)) f.push_back(8'($urandom));
		end
	endfunction

	task automatic random_files(int unsigned byte_goal);
		octet_t f[$];
		while (rand_bytes < byte_goal || rand_files < byte_goal / 40) begin
			rand_file(f);
			send_file(f);
			rand_bytes += f.size();
			rand_files++;
		end
	endtask

	// Fixed files: field extremes, every error code but the position error, early ends
	task automatic run_directed();
		octet_t f[$];
		// smallest good file, rate byte zero takes the default
		f.delete();
		add_header(f, CH_A, CH_Y, 8'd0, 16'd0, 32'd0, 8'd0, 16'd0, FRAME_BYTES);
		add_strings(f, 0);
		f.push_back(8'h00);
		send_file(f);
		// all-ones fields, largest aligned size under the cap
		f.delete();
		add_header(f, CH_Y, CH_M, 8'hff, 16'hffff, 32'hffffffff, 8'hff, 16'hffff,
			(MAX_DATA_RST / FRAME_BYTES) * FRAME_BYTES);
		add_strings(f, 4);
		repeat (8) f.push_back(8'hff);
		send_file(f);
		// first aligned size over the cap
		f.delete();
		add_header(f, CH_A, CH_Y, 8'h5a, 16'h1234, 32'd1773400, 8'd50, 16'd2024,
			(MAX_DATA_RST / FRAME_BYTES + 1) * FRAME_BYTES);
		add_strings(f, 2);
		f.push_back(8'h01);
		send_file(f);
		// zero size, unaligned size, unaligned and huge
		f.delete();
		add_header(f, CH_Y, CH_M, 8'd1, 16'd1, 32'd1, 8'd1, 16'd1, 32'd0);
		add_strings(f, 1);
		f.push_back(8'h80);
		send_file(f);
		f.delete();
		add_header(f, CH_A, CH_Y, 8'd2, 16'd2, 32'd2, 8'd2, 16'd2, 32'd15);
		f.push_back(8'h00);
		send_file(f);
		f.delete();
		add_header(f, CH_A, CH_Y, 8'd3, 16'd3, 32'd3, 8'd3, 16'd3, 32'hffffffff);
		send_file(f);
		// end at the last header byte: bad size wins, good size truncates
		f.delete();
		add_header(f, CH_Y, CH_M, 8'd4, 16'd4, 32'd4, 8'd0, 16'd4, 32'd3);
		send_file(f);
		f.delete();
		add_header(f, CH_Y, CH_M, 8'd4, 16'd4, 32'd4, 8'd0, 16'd4, FRAME_BYTES * 2);
		send_file(f);
		// bad magic at each position, later bytes ignored
		f = '{CH_M, CH_Y, 8'h00, 8'h00};
		send_file(f);
		f = '{CH_A, CH_M};
		send_file(f);
		f = '{CH_Y, CH_Y, 8'h00};
		send_file(f);
		f.delete();
		f.push_back(8'h00);
		repeat (20) f.push_back(8'($urandom));
		send_file(f);
		// single and two byte files
		f = '{CH_A};
		send_file(f);
		f = '{8'h00};
		send_file(f);
		f = '{CH_Y, CH_M};
		send_file(f);
		// end on the fifth terminator, and inside the strings
		f.delete();
		add_header(f, CH_A, CH_Y, 8'd7, 16'd7, 32'd7, 8'd7, 16'd7, FRAME_BYTES);
		add_strings(f, 3);
		send_file(f);
		f.delete();
		add_header(f, CH_A, CH_Y, 8'd8, 16'd8, 32'd8, 8'd8, 16'd8, FRAME_BYTES);
		f.push_back(8'h41);
		f.push_back(8'h00);
		f.push_back(8'h42);
		send_file(f);
		// long payload
		f.delete();
		add_header(f, CH_Y, CH_M, 8'h81, 16'h8001, 32'h80000001, 8'h80, 16'h8001,
			FRAME_BYTES * 1000);
		add_strings(f, 3);
		repeat (30) f.push_back(8'($urandom));
		send_file(f);
	endtask

	// Stimulus and final verdict
	initial begin
		octet_t f[$];
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DEFAULT_RATE;
		cfg_wdata <= '0;
		send_idle_pct = 29;
		recv_idle_pct = 49;
		hold_left = 0;
		bytes_total = 0;
		rand_bytes = 0;
		rand_files = 0;
		cfg_writes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of both registers
		run_directed();
		random_files(150);
		settle();

		// top rate, smallest cap
		write_reg(CFG_DEFAULT_RATE, 24'd255);
		write_reg(CFG_MAX_DATA, 24'd14);
		f.delete();
		add_header(f, CH_A, CH_Y, 8'd9, 16'd9, 32'd9, 8'd0, 16'd9, FRAME_BYTES);
		add_strings(f, 1);
		f.push_back(8'h33);
		send_file(f);
		f.delete();
		add_header(f, CH_A, CH_Y, 8'd9, 16'd9, 32'd9, 8'd0, 16'd9, FRAME_BYTES * 2);
		add_strings(f, 1);
		f.push_back(8'h33);
		send_file(f);
		random_files(300);
		settle();

		// swap idling sides; zero default rate, largest cap
		send_idle_pct = 49;
		recv_idle_pct = 29;
		write_reg(CFG_DEFAULT_RATE, 24'd0);
		write_reg(CFG_MAX_DATA, 24'hffffff);
		f.delete();
		add_header(f, CH_Y, CH_M, 8'd10, 16'd10, 32'd10, 8'd0, 16'd10,
			(32'hffffff / FRAME_BYTES) * FRAME_BYTES);
		add_strings(f, 2);
		f.push_back(8'h7e);
		send_file(f);
		f.delete();
		add_header(f, CH_Y, CH_M, 8'd10, 16'd10, 32'd10, 8'd0, 16'd10,
			(32'hffffff / FRAME_BYTES + 1) * FRAME_BYTES);
		add_strings(f, 2);
		f.push_back(8'h7e);
		send_file(f);
		random_files(450);
		settle();

		// lowest nonzero rate, random cap
		write_reg(CFG_DEFAULT_RATE, 24'd1);
		write_reg(CFG_MAX_DATA, 24'($urandom_range(14, 24'hffffff)));
		random_files(600);
		settle();

		// no idling; hold off the verdict side so the queue fills
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_DEFAULT_RATE, 24'($urandom_range(1, 255)));
		write_reg(CFG_MAX_DATA, 24'($urandom_range(14, 4096)));
		hold_left = 400;
		repeat (12) begin
			f = '{8'($urandom)};
			send_file(f);
		end
		random_files(700);
		random_files(800);
		settle();

		$display("Covered %0d files (%0d accepted) over %0d bytes, %0d register writes.",
			board.files, board.ok_count, bytes_total, cfg_writes);
		$display("Rejects: truncated %0d, magic %0d, size %0d, too large %0d, position %0d.",
			board.code_count[ERR_TRUNC], board.code_count[ERR_MAGIC],
			board.code_count[ERR_SIZE], board.code_count[ERR_LARGE],
			board.code_count[ERR_POS]);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
